### hw/rtl/tkm_pkg.sv
// shared constants, types and the key hash of the triple key match engine
`default_nettype none
package tkm_pkg;

  localparam int TABLE_DEPTH       = 1024;
  localparam int KEY_WIDTH         = 11;
  localparam int OTHER_INDEX_WIDTH = 16;

  localparam int OP_W       = 3;
  localparam int KIND_W     = 2;
  localparam int IDX_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int HASH_AW    = IDX_W + 1;
  localparam int HASH_DEPTH = 2 * TABLE_DEPTH;
  localparam int PKEY_W     = 3 * KEY_WIDTH;
  localparam int OCNT_W     = OTHER_INDEX_WIDTH + 1;
  localparam int HENT_W     = 1 + PKEY_W + IDX_W;
  localparam int MSLOT_W    = 1 + OTHER_INDEX_WIDTH;
  localparam int HASH_NCH   = (PKEY_W + HASH_AW - 1) / HASH_AW;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 3'd0,
    OP_LOAD   = 3'd1,
    OP_BEGIN  = 3'd2,
    OP_MATCH  = 3'd3,
    OP_REPORT = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAIR         = 2'd0,
    KIND_SINGLE_REF   = 2'd1,
    KIND_SINGLE_OTHER = 2'd2,
    KIND_ERROR        = 2'd3
  } kind_t;

  typedef enum logic [3:0] {
    ST_SWEEP_HASH,
    ST_SWEEP_MATCH,
    ST_IDLE,
    ST_DECODE,
    ST_PROBE,
    ST_CHECK,
    ST_RPT_RD,
    ST_RPT_DATA,
    ST_EMIT
  } state_t;

  // xor fold of the packed key down to a hash table address
  function automatic logic [HASH_AW-1:0] key_hash(input logic [PKEY_W-1:0] k);
    logic [HASH_NCH*HASH_AW-1:0] pad;
    logic [HASH_AW-1:0]          h;
    pad = (HASH_NCH*HASH_AW)'(k);
    h   = '0;
    for (int i = 0; i < HASH_NCH; i++) begin
      h = h ^ pad[i*HASH_AW +: HASH_AW];
    end
    return h;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/tkm_in_if.sv
// request channel of the triple key match engine
`default_nettype none
interface tkm_in_if;
  import tkm_pkg::*;
  logic                        valid;
  logic                        ready;
  logic [OP_W-1:0]             operation;
  logic signed [KEY_WIDTH-1:0] key_h;
  logic signed [KEY_WIDTH-1:0] key_k;
  logic signed [KEY_WIDTH-1:0] key_l;
  modport source (output valid, operation, key_h, key_k, key_l, input ready);
  modport sink   (input valid, operation, key_h, key_k, key_l, output ready);
endinterface
`default_nettype wire

### hw/rtl/tkm_out_if.sv
// result channel of the triple key match engine
`default_nettype none
interface tkm_out_if;
  import tkm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic [KIND_W-1:0]            kind;
  logic [IDX_W-1:0]             index_ref;
  logic [OTHER_INDEX_WIDTH-1:0] index_other;
  logic                         last;
  modport source (output valid, kind, index_ref, index_other, last, input ready);
  modport sink   (input valid, kind, index_ref, index_other, last, output ready);
endinterface
`default_nettype wire

### hw/rtl/tkm_ram.sv
// generic single write port ram with registered read
`default_nettype none
module tkm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

### hw/rtl/triple_key_match_engine_top.sv
// triple key match engine: reference key loading, matching and reporting
// requests arrive on in_ch (valid/ready), results leave on out_ch (valid/ready),
// cfg_wr_en/cfg_wr_data write the pairs-only mode bit.
// keys live in a 2*TABLE_DEPTH entry hash ram with linear probing; match slots
// live in a TABLE_DEPTH entry ram indexed by reference position.
// one request at a time: in_ch.ready is high only when the engine is idle.
// load/match: decode, then a probe and a check state per probe step P (usually 1);
// the result is registered, then moved by the emit state into the output register.
// report: decode, match ram read and data states, then emit to the output register.
// clear table sweeps all 2*TABLE_DEPTH (2048) hash ram entries.
// begin round sweeps the loaded match slots, one slot per cycle.
// after reset the hash ram is swept with in_ch.ready low.
// a stalled receiver holds the output register; a new result waits in the
// engine until the register frees, and no further request is taken meanwhile.
`default_nettype none
module triple_key_match_engine_top (
  input  wire logic  clk,
  input  wire logic  rst_n,
  tkm_in_if.sink     in_ch,
  tkm_out_if.source  out_ch,
  input  wire logic  cfg_wr_en,
  input  wire logic  cfg_wr_data
);
  import tkm_pkg::*;

  localparam logic [HASH_AW-1:0] HASH_LAST = HASH_AW'(HASH_DEPTH - 1);
  localparam logic [CNT_W-1:0]   TABLE_FULL = CNT_W'(TABLE_DEPTH);

  state_t                        state_r, state_nxt;
  logic [OP_W-1:0]               op_r, op_nxt;
  logic [PKEY_W-1:0]             key_r, key_nxt;
  logic [HASH_AW-1:0]            addr_r, addr_nxt;
  logic [CNT_W-1:0]              ref_count_r, ref_count_nxt;
  logic [OCNT_W-1:0]             other_count_r, other_count_nxt;
  logic [CNT_W-1:0]              rpt_ptr_r, rpt_ptr_nxt;
  logic [HASH_AW-1:0]            sweep_r, sweep_nxt;
  logic                          pairs_r;
  logic [KIND_W-1:0]             res_kind_r, res_kind_nxt;
  logic [IDX_W-1:0]              res_iref_r, res_iref_nxt;
  logic [OTHER_INDEX_WIDTH-1:0]  res_iother_r, res_iother_nxt;
  logic                          res_last_r, res_last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic [KIND_W-1:0]             out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0]              out_iref_r, out_iref_nxt;
  logic [OTHER_INDEX_WIDTH-1:0]  out_iother_r, out_iother_nxt;
  logic                          out_last_r, out_last_nxt;

  logic                          h_we;
  logic [HASH_AW-1:0]            h_waddr;
  logic [HENT_W-1:0]             h_wdata, h_rdata;
  logic                          m_we;
  logic [IDX_W-1:0]              m_waddr;
  logic [MSLOT_W-1:0]            m_wdata, m_rdata;

  logic                          h_used, h_hit;
  logic [PKEY_W-1:0]             h_key;
  logic [IDX_W-1:0]              h_idx;
  logic [PKEY_W-1:0]             in_key;

  assign h_used = h_rdata[HENT_W-1];
  assign h_key  = h_rdata[IDX_W +: PKEY_W];
  assign h_idx  = h_rdata[IDX_W-1:0];
  assign h_hit  = h_used && (h_key == key_r);
  assign in_key = {in_ch.key_l, in_ch.key_k, in_ch.key_h};

  tkm_ram #(.WIDTH(HENT_W), .DEPTH(HASH_DEPTH)) u_hash_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (addr_r),
    .rdata (h_rdata)
  );

  tkm_ram #(.WIDTH(MSLOT_W), .DEPTH(TABLE_DEPTH)) u_match_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (rpt_ptr_r[IDX_W-1:0]),
    .rdata (m_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SWEEP_HASH;
      ref_count_r   <= '0;
      other_count_r <= '0;
      rpt_ptr_r     <= '0;
      sweep_r       <= '0;
      pairs_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      ref_count_r   <= ref_count_nxt;
      other_count_r <= other_count_nxt;
      rpt_ptr_r     <= rpt_ptr_nxt;
      sweep_r       <= sweep_nxt;
      out_valid_r   <= out_valid_nxt;
      if (cfg_wr_en) begin
        pairs_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    key_r        <= key_nxt;
    addr_r       <= addr_nxt;
    res_kind_r   <= res_kind_nxt;
    res_iref_r   <= res_iref_nxt;
    res_iother_r <= res_iother_nxt;
    res_last_r   <= res_last_nxt;
    out_kind_r   <= out_kind_nxt;
    out_iref_r   <= out_iref_nxt;
    out_iother_r <= out_iother_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    op_nxt          = op_r;
    key_nxt         = key_r;
    addr_nxt        = addr_r;
    ref_count_nxt   = ref_count_r;
    other_count_nxt = other_count_r;
    rpt_ptr_nxt     = rpt_ptr_r;
    sweep_nxt       = sweep_r;
    res_kind_nxt    = res_kind_r;
    res_iref_nxt    = res_iref_r;
    res_iother_nxt  = res_iother_r;
    res_last_nxt    = res_last_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_kind_nxt    = out_kind_r;
    out_iref_nxt    = out_iref_r;
    out_iother_nxt  = out_iother_r;
    out_last_nxt    = out_last_r;
    in_ch.ready     = 1'b0;
    h_we            = 1'b0;
    h_waddr         = addr_r;
    h_wdata         = {1'b1, key_r, ref_count_r[IDX_W-1:0]};
    m_we            = 1'b0;
    m_waddr         = ref_count_r[IDX_W-1:0];
    m_wdata         = '0;

    unique case (state_r)
      ST_SWEEP_HASH: begin
        h_we      = 1'b1;
        h_waddr   = sweep_r;
        h_wdata   = '0;
        sweep_nxt = HASH_AW'(sweep_r + 1'b1);
        if (sweep_r == HASH_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP_MATCH: begin
        m_we      = 1'b1;
        m_waddr   = sweep_r[IDX_W-1:0];
        sweep_nxt = HASH_AW'(sweep_r + 1'b1);
        if (CNT_W'(sweep_r + 1'b1) == ref_count_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          op_nxt    = in_ch.operation;
          key_nxt   = in_key;
          addr_nxt  = key_hash(in_key);
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        res_kind_nxt   = KIND_ERROR;
        res_iref_nxt   = '0;
        res_iother_nxt = '0;
        res_last_nxt   = 1'b0;
        unique case (op_r)
          OP_CLEAR: begin
            ref_count_nxt   = '0;
            other_count_nxt = '0;
            rpt_ptr_nxt     = '0;
            sweep_nxt       = '0;
            state_nxt       = ST_SWEEP_HASH;
          end
          OP_LOAD: begin
            state_nxt = (ref_count_r == TABLE_FULL) ? ST_EMIT : ST_PROBE;
          end
          OP_BEGIN: begin
            other_count_nxt = '0;
            rpt_ptr_nxt     = '0;
            sweep_nxt       = '0;
            state_nxt       = (ref_count_r == '0) ? ST_IDLE : ST_SWEEP_MATCH;
          end
          OP_MATCH: begin
            // count already at 2^width: the index would overflow
            state_nxt = other_count_r[OTHER_INDEX_WIDTH] ? ST_EMIT : ST_PROBE;
          end
          OP_REPORT: begin
            state_nxt = (pairs_r || rpt_ptr_r >= ref_count_r) ? ST_IDLE : ST_RPT_RD;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_PROBE: begin
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (h_used && !h_hit) begin
          addr_nxt  = HASH_AW'(addr_r + 1'b1);
          state_nxt = ST_PROBE;
        end else if (op_r == OP_LOAD) begin
          // same write for a fresh slot and for a duplicate key: newest index wins
          h_we          = 1'b1;
          m_we          = 1'b1;
          ref_count_nxt = CNT_W'(ref_count_r + 1'b1);
          state_nxt     = ST_IDLE;
        end else begin
          other_count_nxt = OCNT_W'(other_count_r + 1'b1);
          res_iref_nxt    = h_idx;
          res_iother_nxt  = other_count_r[OTHER_INDEX_WIDTH-1:0];
          res_last_nxt    = 1'b0;
          state_nxt       = ST_IDLE;
          if (pairs_r) begin
            if (h_hit) begin
              res_kind_nxt = KIND_PAIR;
              state_nxt    = ST_EMIT;
            end
          end else if (!h_hit) begin
            res_kind_nxt = KIND_SINGLE_OTHER;
            res_iref_nxt = '0;
            state_nxt    = ST_EMIT;
          end else begin
            m_we    = 1'b1;
            m_waddr = h_idx;
            m_wdata = {1'b1, other_count_r[OTHER_INDEX_WIDTH-1:0]};
          end
        end
      end
      ST_RPT_RD: begin
        state_nxt = ST_RPT_DATA;
      end
      ST_RPT_DATA: begin
        rpt_ptr_nxt  = CNT_W'(rpt_ptr_r + 1'b1);
        res_iref_nxt = rpt_ptr_r[IDX_W-1:0];
        res_last_nxt = (CNT_W'(rpt_ptr_r + 1'b1) == ref_count_r);
        if (m_rdata[OTHER_INDEX_WIDTH]) begin
          res_kind_nxt   = KIND_PAIR;
          res_iother_nxt = m_rdata[OTHER_INDEX_WIDTH-1:0];
        end else begin
          res_kind_nxt   = KIND_SINGLE_REF;
          res_iother_nxt = '0;
        end
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = res_kind_r;
          out_iref_nxt   = res_iref_r;
          out_iother_nxt = res_iother_r;
          out_last_nxt   = res_last_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.index_ref   = out_iref_r;
  assign out_ch.index_other = out_iother_r;
  assign out_ch.last        = out_last_r;
endmodule
`default_nettype wire

### hw/rtl/tkm_checker.sv
// port level checks of the triple key match engine and their binding
`default_nettype none
module tkm_checker (
  input wire logic                                   clk,
  input wire logic                                   rst_n,
  input wire logic                                   in_valid,
  input wire logic                                   in_ready,
  input wire logic                                   out_valid,
  input wire logic                                   out_ready,
  input wire logic [tkm_pkg::KIND_W-1:0]             out_kind,
  input wire logic [tkm_pkg::IDX_W-1:0]              out_index_ref,
  input wire logic [tkm_pkg::OTHER_INDEX_WIDTH-1:0]  out_index_other,
  input wire logic                                   out_last
);
  import tkm_pkg::*;

  // result waits until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERROR |->
      out_index_ref == '0 && out_index_other == '0 && !out_last)
    else $error("error result carries data");

  a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_kind == KIND_PAIR || out_kind == KIND_SINGLE_REF)
    else $error("last flag outside report");
endmodule

bind triple_key_match_engine_top tkm_checker u_tkm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_index_ref   (out_ch.index_ref),
  .out_index_other (out_ch.index_other),
  .out_last        (out_ch.last)
);
`default_nettype wire
